FILE: design/assert_macros.svh
// assertion macros shared by the tap tempo design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and disabled during rst
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk and disabled during rst
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/tte_pkg.sv
// types and constants shared by the tap tempo period estimator
package tte_pkg;

  localparam int AVG_DEPTH = 8;
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W    = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W     = 32 + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);
  localparam int STEP_W    = $clog2(SUM_W + 1);

  localparam int TOL_W     = 30;
  localparam int BEATS_W   = 5;
  localparam int BEAT_W    = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_CYCLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD    = 2'd1;

  localparam logic [BEATS_W-1:0] BEATS_RESET        = 5'd1;
  localparam logic [31:0]        START_PERIOD_RESET = 32'd500;

  typedef struct packed {
    logic [31:0] edge_time;
    logic        averaging;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       period;
    logic              first_tap;
    logic              out_of_tolerance;
    logic [BEAT_W-1:0] beat_index;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ring_req_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [FILL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/tte_ring.sv
// ring of recent intervals, one write and one registered read per cycle
module tte_ring (
  input  logic              clk,
  input  tte_pkg::ring_req_t req,
  output logic [31:0]       rd_data
);
  import tte_pkg::*;

  logic [31:0] mem [AVG_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: design/tte_div.sv
// restoring divider, one quotient bit per cycle
module tte_div (
  input  logic              clk,
  input  logic              rst,
  input  tte_pkg::div_req_t req,
  output tte_pkg::div_rsp_t rsp
);
  import tte_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [SUM_W-1:0]  dvd;
  logic [SUM_W-1:0]  quo;
  logic [FILL_W-1:0] rem;
  logic [FILL_W-1:0] divisor;
  logic [FILL_W:0]   rem_sh;
  logic              take;
  logic [FILL_W:0]   rem_next;

  // one shift and trial subtract
  always_comb begin
    rem_sh   = {rem, dvd[SUM_W-1]};
    take     = rem_sh >= {1'b0, divisor};
    rem_next = take ? (rem_sh - {1'b0, divisor}) : rem_sh;
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      quo     <= '0;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      quo <= {quo[SUM_W-2:0], take};
      rem <= rem_next[FILL_W-1:0];
    end
  end

  assign rsp = {done, quo[31:0]};

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_no_restart, req.start, !busy, "divider started while busy")
  `ASSERT_IMPL(a_done_after_busy, done, $past(busy), "divider done without a run")
  `ASSERT_NEXT(a_done_pulse, done, !done, "divider done held")

endmodule

FILE: design/tap_tempo_period_estimator.sv
// tap tempo period estimator top level: sequencer, interval state, output register
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+------------------------------
//   in       | input     | in_valid / in_stall | in_item_t: edge_time, averaging
//   out      | output    | out_valid/out_stall | out_item_t: period, flags, beat
//   cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a first tap runs S_TAP, S_BAND, S_STORE and S_FINISH after accept
// any other word runs the same setup states, then S_SUM over fill_count entries,
// S_DIV at one quotient bit per cycle, and S_FINISH
// in_stall is high during rst and from accept until the result is loaded
// a result waiting on out_stall holds the sequencer, not the output register
// rst is synchronous; no clearing pass, the ring is tracked by fill_count
module tap_tempo_period_estimator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tte_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tte_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);
  import tte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP,
    S_BAND,
    S_STORE,
    S_SUM,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;

  // configuration and persistent state
  logic [BEATS_W-1:0] beats_per_cycle;
  logic [31:0]        applied_period;
  logic [31:0]        last_edge_time;
  logic [31:0]        last_interval;
  logic [TOL_W-1:0]   tolerance;
  logic [SLOT_W-1:0]  write_slot;
  logic [FILL_W-1:0]  fill_count;
  logic [BEAT_W-1:0]  beat_counter;

  // per-word working registers
  logic [31:0]        interval;
  logic               use_avg;
  logic               first;
  logic               below;
  logic               above;
  logic               flag;
  logic [FILL_W-1:0]  rd_cnt;
  logic [FILL_W-1:0]  add_cnt;
  logic               rd_pend;
  logic [SUM_W-1:0]   sum;

  // combinational helpers
  logic               in_accept;
  logic               cfg_accept;
  logic               outside;
  logic               ring_clear;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_next;
  logic [FILL_W-1:0]  fill_next;
  logic [TOL_W-1:0]   tol_next;
  logic [BEATS_W-1:0] beat_inc;
  logic [BEAT_W-1:0]  beat_next;
  logic [SUM_W-1:0]   sum_next;
  logic               last_add;
  logic               out_free;

  ring_req_t          ring_req;
  logic [31:0]        ring_rd_data;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // registers are written only while idle, so no word sees a mid-flight change
  assign in_stall   = rst || (state != S_IDLE);
  assign cfg_ready  = !rst && (state == S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign out_free   = !out_valid || !out_stall;

  // store update: band restart or non-averaging restart empties the ring
  always_comb begin
    outside    = below || above;
    ring_clear = outside || (!first && !use_avg);
    slot       = ring_clear ? '0 : write_slot;
    slot_next  = (slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot + 1'b1;
    if (ring_clear) begin
      fill_next = FILL_W'(1);
    end else if (fill_count < FILL_W'(AVG_DEPTH)) begin
      fill_next = fill_count + 1'b1;
    end else begin
      fill_next = fill_count;
    end
    tol_next  = (interval[31:2] == '0) ? TOL_W'(1) : interval[31:2];
    beat_inc  = {1'b0, beat_counter} + 1'b1;
    beat_next = (beat_inc >= beats_per_cycle || beat_inc > BEATS_W'(15)) ?
                '0 : beat_inc[BEAT_W-1:0];
  end

  // summing: reads issued one a cycle, each added in the cycle after its read
  always_comb begin
    sum_next = sum + {{(SUM_W-32){1'b0}}, ring_rd_data};
    last_add = rd_pend && (FILL_W'(add_cnt + 1'b1) == fill_count);
  end

  // ring port requests
  always_comb begin
    ring_req.wr_en   = (state == S_STORE);
    ring_req.wr_addr = slot;
    ring_req.wr_data = interval;
    ring_req.rd_en   = (state == S_SUM) && (rd_cnt != fill_count);
    ring_req.rd_addr = rd_cnt[SLOT_W-1:0];
  end

  // divider request
  always_comb begin
    div_req.start    = (state == S_SUM) && last_add;
    div_req.dividend = sum_next;
    div_req.divisor  = fill_count;
  end

  tte_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rd_data)
  );

  tte_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      beats_per_cycle <= BEATS_RESET;
      applied_period  <= START_PERIOD_RESET;
      last_edge_time  <= '0;
      last_interval   <= '0;
      tolerance       <= '0;
      write_slot      <= '0;
      fill_count      <= '0;
      beat_counter    <= '0;
      rd_pend         <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_accept) begin
        unique case (cfg_index)
          CFG_BEATS_PER_CYCLE: beats_per_cycle <= cfg_data[BEATS_W-1:0];
          CFG_START_PERIOD:    applied_period  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            interval       <= in_data.edge_time - last_edge_time;
            use_avg        <= in_data.averaging;
            last_edge_time <= in_data.edge_time;
            state          <= S_TAP;
          end
        end
        S_TAP: begin
          first <= {2'b00, interval} > {last_interval, 2'b00};
          below <= ({1'b0, interval} + {3'b000, tolerance}) < {1'b0, last_interval};
          state <= S_BAND;
        end
        S_BAND: begin
          above <= {1'b0, interval} > ({1'b0, last_interval} + {3'b000, tolerance});
          state <= S_STORE;
        end
        S_STORE: begin
          last_interval <= interval;
          tolerance     <= tol_next;
          write_slot    <= slot_next;
          fill_count    <= fill_next;
          flag          <= !first && outside;
          beat_counter  <= first ? '0 : beat_next;
          rd_cnt        <= '0;
          add_cnt       <= '0;
          rd_pend       <= 1'b0;
          sum           <= '0;
          state         <= first ? S_FINISH : S_SUM;
        end
        S_SUM: begin
          rd_pend <= ring_req.rd_en;
          if (ring_req.rd_en) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (rd_pend) begin
            sum     <= sum_next;
            add_cnt <= add_cnt + 1'b1;
          end
          if (last_add) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            applied_period <= div_rsp.quotient;
            state          <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_data.period           <= applied_period;
            out_data.first_tap        <= first;
            out_data.out_of_tolerance <= flag;
            out_data.beat_index       <= beat_counter;
            out_valid                 <= 1'b1;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_word_from_finish, $rose(out_valid), $past(state == S_FINISH), "word loaded outside finish")
  `ASSERT_IMPL(a_flags_exclusive, out_valid, !(out_data.first_tap && out_data.out_of_tolerance), "first tap flagged out of tolerance")
  `ASSERT_IMPL(a_first_tap_beat, out_valid && out_data.first_tap, out_data.beat_index == '0, "first tap with nonzero beat")
  `ASSERT_NEXT(a_sum_has_entries, state == S_STORE && !first, fill_count != '0 && fill_count <= FILL_W'(AVG_DEPTH), "averaging over an empty ring")

endmodule

FILE: tb/tempo_check_pkg.sv
// period tracker and result scoreboard for the tap tempo period estimator bench
`timescale 1ns / 1ps

package tempo_check_pkg;
  import tte_pkg::*;

  class period_tracker;
    // register copies
    logic [BEATS_W-1:0] beats;
    logic [31:0] start_per;
    // interval state
    logic [31:0] last_edge;
    logic [31:0] last_gap;
    logic [TOL_W-1:0] band;
    logic [31:0] ring[AVG_DEPTH];
    int unsigned slot;
    int unsigned filled;
    logic [31:0] period_now;
    logic [BEAT_W-1:0] beat;
    // words still to come out of the block, oldest first
    out_item_t pending_periods[$];
    int unsigned mismatches;

    function new();
      beats = BEATS_RESET;
      start_per = START_PERIOD_RESET;
      last_edge = '0;
      last_gap = '0;
      band = '0;
      foreach (ring[i]) ring[i] = '0;
      slot = 0;
      filled = 0;
      period_now = START_PERIOD_RESET;
      beat = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_BEATS_PER_CYCLE: beats = data[BEATS_W-1:0];
        CFG_START_PERIOD: begin
          start_per = data;
          period_now = data;
        end
        default: ;
      endcase
    endfunction

    function void clear_ring();
      slot = 0;
      filled = 0;
    endfunction

    // band of last interval plus or minus a quarter, no wrap at 32 bits
    function bit outside_band(logic [31:0] gap);
      logic [33:0] v;
      logic [33:0] l;
      logic [33:0] t;
      v = {2'b00, gap};
      l = {2'b00, last_gap};
      t = {4'b0000, band};
      return (v + t < l) || (v > l + t);
    endfunction

    // store one interval, restarting the ring when it leaves the band
    function void keep_gap(logic [31:0] gap);
      if (outside_band(gap)) clear_ring();
      ring[slot[SLOT_W-1:0]] = gap;
      last_gap = gap;
      band = gap[31:2];
      if (band == '0) band = TOL_W'(1);
      slot = (slot + 1) % AVG_DEPTH;
      if (filled < AVG_DEPTH) filled++;
    endfunction

    // work out the result of one accepted edge word
    function void note_edge(in_item_t w);
      logic [31:0] gap;
      int unsigned nb;
      logic [63:0] total;
      out_item_t want;
      gap = w.edge_time - last_edge;
      last_edge = w.edge_time;
      want.first_tap = ({32'd0, gap} > {30'd0, last_gap, 2'b00});
      want.out_of_tolerance = 1'b0;
      if (want.first_tap) begin
        beat = '0;
        keep_gap(gap);
      end else begin
        nb = beat + 1;
        if (nb >= beats || nb > 15) nb = 0;
        beat = nb[BEAT_W-1:0];
        want.out_of_tolerance = outside_band(gap);
        if (!w.averaging) clear_ring();
        keep_gap(gap);
        // integer mean of the latest intervals, at most AVG_DEPTH, since the last restart
        total = '0;
        for (int i = 0; i < filled; i++) total += 64'(ring[SLOT_W'(i)]);
        period_now = 32'(total / 64'(filled));
      end
      want.period = period_now;
      want.beat_index = beat;
      pending_periods.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (pending_periods.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_periods.pop_front();
      compare_field("period", want.period, got.period);
      compare_field("first_tap", 32'(want.first_tap), 32'(got.first_tap));
      compare_field("out_of_tolerance", 32'(want.out_of_tolerance),
                    32'(got.out_of_tolerance));
      compare_field("beat_index", 32'(want.beat_index), 32'(got.beat_index));
    endfunction
  endclass

endpackage

FILE: tb/testbench.sv
// top level bench: drives edge words and register writes, checks period words
`timescale 1ns / 1ps

module testbench;
  import tte_pkg::*;
  import tempo_check_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned PHASE_WORDS = 264;
  localparam int unsigned IDLE_PCT = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  period_tracker tracker = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] edge_now = '0;
  logic [31:0] gap_base = 32'd1000;

  tap_tempo_period_estimator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // output side: check accepted words, random stall, one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_word(out_data);
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one edge word and wait for it to be taken
  task automatic send_edge(logic [31:0] t, logic avg);
    in_item_t w;
    w.edge_time = t;
    w.averaging = avg;
    edge_now = t;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_edge(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  // stop offering and wait for every outstanding period word
  task automatic settle(int unsigned extra);
    in_valid <= 1'b0;
    while (tracker.pending_periods.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // steady tempo runs with jitter inside the band, plus band breaks,
  // first taps and random edge times
  task automatic run_tempo(int unsigned count);
    int unsigned sent;
    int unsigned kind;
    int unsigned sel;
    int unsigned jit;
    int unsigned runlen;
    logic [31:0] gap;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        sel = $urandom_range(9);
        if (sel == 0) gap_base = $urandom_range(1, 8);
        else if (sel == 1) gap_base = $urandom;
        else gap_base = $urandom_range(16, 5000);
        runlen = $urandom_range(3, 20);
        for (int j = 0; j < runlen && sent < count; j++) begin
          jit = gap_base >> 4;
          gap = gap_base - jit + $urandom_range(2 * jit);
          send_edge(edge_now + gap, $urandom_range(9) != 0);
          sent++;
        end
      end else if (kind < 80) begin
        gap = $urandom_range(1) ? gap_base + (gap_base >> 1) + 1 : gap_base >> 1;
        send_edge(edge_now + gap, 1'($urandom_range(1)));
        sent++;
      end else if (kind < 88) begin
        gap = gap_base * 5 + 1;
        send_edge(edge_now + gap, 1'($urandom_range(1)));
        sent++;
      end else begin
        send_edge($urandom, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] beats_plan[7];
    logic [31:0] start_plan[7];
    beats_plan = '{32'd16, 32'd0, ($urandom & 32'hFFFF_FFE0) | 32'd31, 32'd17,
                   32'd2, $urandom_range(1, 16), 32'd5};
    start_plan = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1,
                   $urandom_range(100, 3000), $urandom, 32'd500};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: tiny intervals, wrap of the tick counter, band edges, zero interval
    send_edge(32'd0, 1'b1);
    send_edge(32'd1, 1'b1);
    send_edge(32'd3, 1'b1);
    send_edge(32'd5, 1'b0);
    send_edge(32'd8, 1'b1);
    send_edge(32'hFFFF_FFFF, 1'b1);
    send_edge(32'd3, 1'b1);
    send_edge(edge_now + 32'd1000, 1'b1);
    send_edge(edge_now + 32'd1000, 1'b1);
    send_edge(edge_now + 32'd1000, 1'b1);
    send_edge(edge_now + 32'd1250, 1'b1);
    send_edge(edge_now + 32'd1563, 1'b1);
    send_edge(edge_now + 32'd100, 1'b1);
    send_edge(edge_now, 1'b1);
    send_edge(edge_now + 32'd1, 1'b0);
    send_edge(edge_now + 32'hFFFF_FFFF, 1'b1);
    send_edge(edge_now + 32'h7FFF_FFFF, 1'b1);
    send_edge(edge_now + 32'h8000_0000, 1'b0);
    send_edge(32'hAAAA_AAAA, 1'b1);
    send_edge(32'h5555_5555, 1'b1);

    // register settings, each followed by random traffic
    for (int p = 0; p < 7; p++) begin
      settle(8);
      write_reg(CFG_BEATS_PER_CYCLE, beats_plan[p]);
      write_reg(CFG_START_PERIOD, start_plan[p]);
      write_reg($urandom_range(1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, $urandom);
      cfg_valid <= 1'b0;
      if (p == 1) hold_req = 1'b1;
      calm = (p == 2);
      run_tempo(PHASE_WORDS);
    end

    settle(60);
    if (tracker.mismatches == 0 && tracker.pending_periods.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
